// ===== rtl/indexed_list_shift_array_core_assert.svh =====
// Assertion macros used by the checker file of the list core
`ifndef INDEXED_LIST_SHIFT_ARRAY_CORE_ASSERT_SVH
`define INDEXED_LIST_SHIFT_ARRAY_CORE_ASSERT_SVH

// property must hold at every edge outside reset
`define ILSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("list core check failed");

// condition must never be seen outside reset
`define ILSA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("list core forbidden condition seen");

`endif

// ===== rtl/ilsa_pkg.sv =====
// Types and constants of the list core
package ilsa_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int POS_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } t_state;

    typedef enum logic [2:0] {
        SEL_HOLD  = 3'd0,
        SEL_LOAD  = 3'd1,
        SEL_LEFT  = 3'd2,
        SEL_RIGHT = 3'd3,
        SEL_FIRST = 3'd4
    } t_cell_sel;

endpackage

// ===== rtl/ilsa_stream_if.sv =====
// Request and result channel interfaces of the list core
interface ilsa_in_if;
    logic                                valid;
    logic                                ready;
    logic [ilsa_pkg::OP_W-1:0]           operation;
    logic [ilsa_pkg::IDX_W-1:0]          index;
    logic signed [ilsa_pkg::VAL_W-1:0]   value;

    modport source (output valid, operation, index, value, input ready);
    modport sink   (input valid, operation, index, value, output ready);
endinterface

interface ilsa_out_if;
    logic                                valid;
    logic                                ready;
    logic [ilsa_pkg::STAT_W-1:0]         status;
    logic [ilsa_pkg::CNT_W-1:0]          count;
    logic signed [ilsa_pkg::VAL_W-1:0]   element;
    logic [ilsa_pkg::POS_W-1:0]          element_position;
    logic                                last;

    modport source (output valid, status, count, element, element_position, last,
                    input ready);
    modport sink   (input valid, status, count, element, element_position, last,
                    output ready);
endinterface

// ===== rtl/ilsa_cell.sv =====
// One storage cell of the list chain
module ilsa_cell (
    input  logic                              i_clk,
    input  ilsa_pkg::t_cell_sel               i_sel,
    input  logic signed [ilsa_pkg::VAL_W-1:0] i_value,
    input  logic signed [ilsa_pkg::VAL_W-1:0] i_left,
    input  logic signed [ilsa_pkg::VAL_W-1:0] i_right,
    input  logic signed [ilsa_pkg::VAL_W-1:0] i_first,
    output logic signed [ilsa_pkg::VAL_W-1:0] o_data
);
    import ilsa_pkg::*;

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;

    always_comb begin
        unique case (i_sel)
            SEL_HOLD:  n_data = r_data;
            SEL_LOAD:  n_data = i_value;
            SEL_LEFT:  n_data = i_left;
            SEL_RIGHT: n_data = i_right;
            SEL_FIRST: n_data = i_first;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/indexed_list_shift_array_core.sv =====
// Top level of the fixed-capacity ordered list core
//
// Channels: i_in carries one request beat (operation, index, value); o_out
// carries result beats (status, count, element, element_position, last).
// Append, insert and remove: the request is accepted, every
// cell of the chain shifts or loads at once, and the single result beat is
// valid in the next cycle. One such request per cycle is sustained while
// the receiver keeps up.
// Dump of N entries: the request is accepted, then one entry beat per cycle
// unless stalled, last set on the final one; requests are not taken meanwhile.
// The chain rotates its live entries toward the head cell once per beat, so
// the rate is set by that single head read; after N rotations the order is
// restored. A dump of an empty list gives one beat with status empty.
// Reset clears the entry count, the controller and the output valid flag;
// cell contents stay as they were and are never read before written.
// A stall on o_out holds the result register and the chain; a new request
// is taken only when the result register is empty or drains in that cycle.
module indexed_list_shift_array_core #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilsa_in_if.sink    i_in,
    ilsa_out_if.source o_out
);
    import ilsa_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [AW-1:0]           r_pos;
    logic [AW-1:0]           n_pos;

    logic                    r_ov;
    logic                    n_ov;
    t_status                 r_status;
    t_status                 n_status;
    logic [CNT_W-1:0]        r_ocount;
    logic [CNT_W-1:0]        n_ocount;
    logic signed [VAL_W-1:0] r_elem;
    logic signed [VAL_W-1:0] n_elem;
    logic [POS_W-1:0]        r_epos;
    logic [POS_W-1:0]        n_epos;
    logic                    r_last;
    logic                    n_last;

    logic                    slot_free;
    logic                    in_fire;
    logic                    dump_step;
    logic                    dump_last;
    logic                    full;
    logic [CMPW-1:0]         idx_x;
    logic [CMPW-1:0]         cnt_x;
    logic [CMPW-1:0]         ins_pos;
    logic                    do_ins;
    logic                    do_rem;
    t_status                 req_status;
    t_op                     op;

    t_cell_sel               w_sel  [CAPACITY];
    logic signed [VAL_W-1:0] w_cell [CAPACITY];

    assign op        = t_op'(i_in.operation);
    assign slot_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && slot_free;
    assign in_fire   = i_in.valid && i_in.ready;
    assign dump_step = (r_state == ST_DUMP) && slot_free;
    assign dump_last = (CW'(r_pos) + CW'(1)) == r_count;
    assign full      = r_count == CW'(CAPACITY);
    assign idx_x     = CMPW'(i_in.index);
    assign cnt_x     = CMPW'(r_count);

    // request decode
    always_comb begin
        req_status = STAT_OK;
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        ins_pos    = cnt_x;
        unique case (op)
            OP_APPEND: begin
                if (full) begin
                    req_status = STAT_FULL;
                end else begin
                    do_ins = in_fire;
                end
            end
            OP_INSERT: begin
                ins_pos = idx_x;
                if (idx_x > cnt_x) begin
                    req_status = STAT_RANGE;
                end else if (full) begin
                    req_status = STAT_FULL;
                end else begin
                    do_ins = in_fire;
                end
            end
            OP_REMOVE: begin
                if (idx_x >= cnt_x) begin
                    req_status = STAT_RANGE;
                end else begin
                    do_rem = in_fire;
                end
            end
            OP_DUMP: begin
                req_status = (r_count == '0) ? STAT_EMPTY : STAT_OK;
            end
            default: req_status = STAT_OK;
        endcase
    end

    // per-cell move select
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel[i] = SEL_HOLD;
            if (do_ins) begin
                if (CMPW'(i) == ins_pos) begin
                    w_sel[i] = SEL_LOAD;
                end else if (CMPW'(i) > ins_pos && CMPW'(i) <= cnt_x) begin
                    w_sel[i] = SEL_LEFT;
                end
            end else if (do_rem) begin
                if (CMPW'(i) >= idx_x && CMPW'(i + 1) < cnt_x) begin
                    w_sel[i] = SEL_RIGHT;
                end
            end else if (dump_step) begin
                if (CMPW'(i + 1) < cnt_x) begin
                    w_sel[i] = SEL_RIGHT;
                end else if (CMPW'(i + 1) == cnt_x) begin
                    w_sel[i] = SEL_FIRST;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        ilsa_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[g]),
            .i_value (i_in.value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_first (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && op == OP_DUMP && r_count != '0) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (dump_step && dump_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result register and counters
    always_comb begin
        n_ov     = r_ov && !o_out.ready;
        n_status = r_status;
        n_ocount = r_ocount;
        n_elem   = r_elem;
        n_epos   = r_epos;
        n_last   = r_last;
        n_count  = r_count;
        n_pos    = r_pos;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_rem) begin
            n_count = r_count - CW'(1);
        end
        if (in_fire) begin
            n_pos = '0;
            if (op != OP_DUMP || r_count == '0) begin
                n_ov     = 1'b1;
                n_status = req_status;
                n_ocount = CNT_W'(n_count);
                n_elem   = '0;
                n_epos   = '0;
                n_last   = 1'b1;
            end
        end else if (dump_step) begin
            n_ov     = 1'b1;
            n_status = STAT_OK;
            n_ocount = CNT_W'(r_count);
            n_elem   = w_cell[0];
            n_epos   = POS_W'(r_pos);
            n_last   = dump_last;
            n_pos    = r_pos + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ocount <= n_ocount;
        r_elem   <= n_elem;
        r_epos   <= n_epos;
        r_last   <= n_last;
    end

    assign o_out.valid            = r_ov;
    assign o_out.status           = r_status;
    assign o_out.count            = r_ocount;
    assign o_out.element          = r_elem;
    assign o_out.element_position = r_epos;
    assign o_out.last             = r_last;

endmodule

// ===== rtl/ilsa_chk.sv =====
// Port-level checker of the list core and its bind
`include "indexed_list_shift_array_core_assert.svh"

module ilsa_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [ilsa_pkg::STAT_W-1:0]       i_out_status,
    input logic [ilsa_pkg::CNT_W-1:0]        i_out_count,
    input logic signed [ilsa_pkg::VAL_W-1:0] i_out_element,
    input logic                              i_out_last
);
    import ilsa_pkg::*;

    logic                           w_stall;
    logic [STAT_W+CNT_W+VAL_W:0]    w_beat;
    logic                           w_empty;
    logic                           w_empty_ok;

    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_beat     = {i_out_status, i_out_count, i_out_element, i_out_last};
    assign w_empty    = i_out_valid && (i_out_status == STAT_EMPTY);
    assign w_empty_ok = (i_out_count == '0) && i_out_last && (i_out_element == '0);

    // stalled result beat holds
    `ILSA_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> (i_out_valid && $stable(w_beat)))

    // mid-dump beat on the output: no request taken
    `ILSA_ASSERT(a_dump_blocks, i_clk, i_rst_n, (i_out_valid && !i_out_last) |-> !i_in_ready)

    // empty dump reports zero entries and ends the burst
    `ILSA_ASSERT(a_empty_beat, i_clk, i_rst_n, w_empty |-> w_empty_ok)

    // an error never sits inside a dump burst
    `ILSA_NEVER(a_err_last, i_clk, i_rst_n, i_out_valid && i_out_status != STAT_OK && !i_out_last)

endmodule

bind indexed_list_shift_array_core ilsa_chk u_ilsa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_count   (o_out.count),
    .i_out_element (o_out.element),
    .i_out_last    (o_out.last)
);
